// ===== hdl/urr_pkg.sv =====
// ----------------------------------------------------------------------------
// Uniform range reducer package
// Shared types and constants for the range reducer and its division cells.
// ----------------------------------------------------------------------------
`default_nettype none

package urr_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned NumCells = WordW;

  typedef struct packed {
    logic [WordW-1:0] lower_bound;
    logic [WordW-1:0] upper_bound;
    logic [WordW-1:0] random_word;
  } request_t;

  typedef struct packed {
    logic             accepted;
    logic [WordW-1:0] ranged_value;
  } result_t;

  // One slot of the division chain. The shifted copy of the word feeds the
  // remainder one bit per cell, most significant bit first.
  typedef struct packed {
    logic             valid;
    logic [WordW-1:0] lower_bound;
    logic [WordW-1:0] size;
    logic [WordW-1:0] random_word;
    logic [WordW-1:0] dividend;
    logic [WordW-1:0] rem_word;
    logic [WordW-1:0] rem_ones;
  } stage_t;

endpackage

`default_nettype wire

// ===== hdl/urr_cell.sv =====
// ----------------------------------------------------------------------------
// Range reducer division cell
// One restoring step of the word remainder and of the all-ones remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module urr_cell
  import urr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   enable,
  input  wire stage_t prev,
  output stage_t      cur
);

  logic [WordW:0] trial_word;
  logic [WordW:0] trial_ones;
  logic [WordW:0] size_ext;
  stage_t         cur_next;

  always_comb begin
    size_ext   = {1'b0, prev.size};
    trial_word = {prev.rem_word, prev.dividend[WordW-1]};
    trial_ones = {prev.rem_ones, 1'b1};
    cur_next   = prev;
    cur_next.dividend = {prev.dividend[WordW-2:0], 1'b0};
    if (trial_word >= size_ext) begin
      trial_word = trial_word - size_ext;
    end
    if (trial_ones >= size_ext) begin
      trial_ones = trial_ones - size_ext;
    end
    cur_next.rem_word = trial_word[WordW-1:0];
    cur_next.rem_ones = trial_ones[WordW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (enable) begin
      cur <= cur_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/uniform_range_reducer.sv =====
// ----------------------------------------------------------------------------
// Uniform range reducer
// Maps a random word onto an inclusive range with modulo rejection.
// ----------------------------------------------------------------------------
// One request is taken per cycle unless a valid result is stalled, and each
// gives one result: a chain of 64 division cells forms one remainder bit per cell,
// and a final register applies the rejection limit and adds the lower bound. The
// whole chain advances together whenever the result register is free or taken.
`default_nettype none

module uniform_range_reducer
  import urr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     request_valid,
  output logic          request_stall,
  input  wire request_t request,
  output logic          result_valid,
  input  wire logic     result_stall,
  output result_t       result
);

  logic   advance;
  stage_t chain [NumCells+1];
  stage_t last;
  logic   size_zero;
  result_t result_next;

  assign advance       = !result_valid || !result_stall;
  assign request_stall = !advance;

  always_comb begin
    chain[0].valid       = request_valid;
    chain[0].lower_bound = request.lower_bound;
    chain[0].size        = request.upper_bound + WordW'(1) - request.lower_bound;
    chain[0].random_word = request.random_word;
    chain[0].dividend    = request.random_word;
    chain[0].rem_word    = '0;
    chain[0].rem_ones    = '0;
  end

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    urr_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .enable (advance),
      .prev   (chain[i]),
      .cur    (chain[i+1])
    );
  end

  assign last      = chain[NumCells];
  assign size_zero = (last.size == '0);

  always_comb begin
    result_next = '0;
    if (size_zero) begin
      result_next.accepted     = 1'b1;
      result_next.ranged_value = last.random_word;
    end else if (last.random_word < ~last.rem_ones) begin
      result_next.accepted     = 1'b1;
      result_next.ranged_value = last.lower_bound + last.rem_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= last.valid;
    end
    if (advance) begin
      result <= result_next;
    end
  end

  a_reset_clears : assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid after reset");
  a_reject_zero : assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.accepted |-> result.ranged_value == '0)
    else $error("rejected transfer carries a value");
  a_rem_bound : assert property (@(posedge clk) disable iff (rst)
    last.valid && !size_zero |-> last.rem_word < last.size && last.rem_ones < last.size)
    else $error("remainder not below range size");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Uniform range reducer testbench
// Drives range requests with random idling on both channels, predicts each
// result with a 64-bit arithmetic model of modulo rejection and checks the
// results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
  import urr_pkg::*;
();

  localparam int unsigned Latency = 70;
  localparam longint unsigned CycleLimit = 400000;

  logic     clk;
  logic     rst;
  logic     request_valid;
  logic     request_stall;
  request_t request;
  logic     result_valid;
  logic     result_stall;
  result_t  result;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatches;
  longint unsigned cycles;
  result_t expected_results[$];

  uniform_range_reducer dut (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic result_t reduce_to_range(request_t req);
    logic [WordW-1:0] size;
    logic [WordW-1:0] limit;
    result_t res;
    size = req.upper_bound + 64'd1 - req.lower_bound;
    res.accepted = 1'b1;
    res.ranged_value = req.random_word;
    if (size != '0) begin
      limit = ({64{1'b1}} / size) * size;
      if (req.random_word < limit) begin
        res.ranged_value = req.lower_bound + (req.random_word % size);
      end else begin
        res.accepted = 1'b0;
        res.ranged_value = '0;
      end
    end
    return res;
  endfunction

  function automatic logic [WordW-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
    if (!rst) begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("Unexpected result %h", result);
        end else begin
          if (result.accepted !== expected_results[0].accepted ||
              result.ranged_value !== expected_results[0].ranged_value) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) begin
              $display("Mismatch: expected %b %h, got %b %h",
                       expected_results[0].accepted, expected_results[0].ranged_value,
                       result.accepted, result.ranged_value);
            end
          end
          void'(expected_results.pop_front());
        end
      end
    end
  end

  task automatic send_request(logic [WordW-1:0] lo, logic [WordW-1:0] hi,
                              logic [WordW-1:0] word);
    request_t req;
    req.lower_bound = lo;
    req.upper_bound = hi;
    req.random_word = word;
    while ($urandom_range(99) < send_idle_pct) begin
      request_valid <= 1'b0;
      @(posedge clk);
    end
    request_valid <= 1'b1;
    request <= req;
    @(posedge clk);
    while (request_stall) @(posedge clk);
    expected_results.push_back(reduce_to_range(req));
  endtask

  task automatic drain();
    request_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [WordW-1:0] ones;
    ones = {64{1'b1}};
    send_request(64'd0, ones, 64'd0);
    send_request(64'd0, ones, ones);
    send_request(64'd5, 64'd4, 64'h1234_5678_9abc_def0);
    send_request(64'd0, 64'd0, ones);
    send_request(64'd0, 64'd0, 64'd0);
    send_request(ones, ones, ones);
    send_request(64'd0, 64'd9, ones);
    send_request(64'd0, 64'd9, ones - 64'd5);
    send_request(64'd0, 64'd9, ones - 64'd6);
    send_request(64'd0, 64'd7, ones);
    send_request(64'd0, 64'd7, ones - 64'd1);
    send_request(ones - 64'd2, 64'd3, ones - 64'd20);
    send_request(ones - 64'd2, 64'd3, 64'd100);
    send_request(64'd0, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_request(64'd0, 64'h8000_0000_0000_0000, ones);
    send_request(64'd1, ones, ones);
    send_request(64'd1, ones, ones - 64'd1);
    send_request(64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_fffe, ones - 64'd1);
    send_request(ones, 64'd0, 64'd3);
    drain();
  endtask

  task automatic test_random(int unsigned count);
    logic [WordW-1:0] lo;
    logic [WordW-1:0] hi;
    logic [WordW-1:0] span;
    for (int unsigned i = 0; i < count; i++) begin
      lo = rand_word();
      case ($urandom_range(4))
        0: span = 64'($urandom_range(16));
        1: span = rand_word() >> $urandom_range(63);
        2: span = {64{1'b1}} - 64'($urandom_range(3));
        3: span = (64'd1 << $urandom_range(63)) - 64'd1;
        default: span = rand_word();
      endcase
      hi = lo + span;
      if ($urandom_range(5) == 0) lo = 64'd0;
      send_request(lo, hi, ($urandom_range(3) == 0) ?
                   ({64{1'b1}} - 64'($urandom_range(1000))) : rand_word());
    end
  endtask

  task automatic test_pause();
    drain();
    test_random(5);
  endtask

  initial begin
    cycles = 0;
    mismatches = 0;
    rst = 1'b1;
    request_valid = 1'b0;
    request = '0;
    result_stall = 1'b0;
    send_idle_pct = 11;
    recv_idle_pct = 68;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(200);
    test_pause();
    send_idle_pct = 68;
    recv_idle_pct = 11;
    test_random(200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(200);
    drain();
    repeat (Latency) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== uniform_range_reducer.f =====
hdl/urr_pkg.sv
hdl/urr_cell.sv
hdl/uniform_range_reducer.sv
dv/testbench.sv
